// File: src/rfr_pkg.sv
// Package for the radio frame receiver: frame layout constants, status codes
// and the modular Fletcher add. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rfr_pkg;

    localparam logic [7:0] SYNC0_BYTE    = 8'h48;
    localparam logic [7:0] SYNC1_BYTE    = 8'h65;
    localparam logic [7:0] RESP_BYTE     = 8'h20;
    localparam logic [7:0] CMD_MIN       = 8'h01;
    localparam logic [7:0] CMD_MAX       = 8'h20;
    localparam logic [7:0] HI_ACK        = 8'h0A;
    localparam logic [7:0] HI_NACK       = 8'hFF;
    localparam logic [7:0] HI_NONE       = 8'h00;
    localparam logic [8:0] SHORT_FRAME   = 9'd8;
    localparam logic [8:0] END_UNKNOWN   = 9'd255;
    localparam logic [8:0] FRAME_OVERHEAD = 9'd10;

    localparam logic [8:0] IDX_RESP      = 9'd2;
    localparam logic [8:0] IDX_CMD       = 9'd3;
    localparam logic [8:0] IDX_LEN_HI    = 9'd4;
    localparam logic [8:0] IDX_LEN_LO    = 9'd5;
    localparam logic [8:0] IDX_HCHK0     = 9'd6;
    localparam logic [8:0] IDX_HCHK1     = 9'd7;
    localparam logic [8:0] IDX_PAYLOAD   = 9'd8;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NACK       = 3'd1;
    localparam logic [2:0] ST_EMPTY      = 3'd2;
    localparam logic [2:0] ST_BAD_ACK    = 3'd3;
    localparam logic [2:0] ST_CHECK_FAIL = 3'd4;
    localparam logic [2:0] ST_ZERO_LEN   = 3'd5;

    localparam logic [8:0] MOD255_ONCE   = 9'd255;
    localparam logic [8:0] MOD255_TWICE  = 9'd510;

    // Adds two bytes modulo 255 or 256. Operands can reach 255 even in
    // modulo 255 mode after a mode change, so the sum may need two folds.
    function automatic logic [7:0] mod_add(input logic [7:0] a, input logic [7:0] b,
                                           input logic mod256);
        logic [8:0] sum;
        logic [8:0] red;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= MOD255_TWICE)
            red = sum - MOD255_TWICE;
        else if (sum >= MOD255_ONCE)
            red = sum - MOD255_ONCE;
        else
            red = sum;
        return mod256 ? sum[7:0] : red[7:0];
    endfunction

endpackage
`default_nettype wire

// File: src/radio_frame_receiver.sv
// Radio frame receiver top level: byte parser, Fletcher checking and result register.
// Depends on rfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Usage
// The receiver takes one radio byte per item on the input channel (in_valid,
// in_stall, rx_byte) and emits results on the output channel (out_valid,
// out_stall and the result fields). Each accepted byte produces either no
// result or one: a payload byte item with kind low while a frame's payload
// streams past, or a status item with kind and last high on the final byte
// of a frame.
// The parser state is updated at the edge that accepts a byte, and the
// result sits in a result register from the next cycle. One byte is accepted
// every cycle unless a held result stalls the output; the figure is set by the
// single pass of compare and modular add logic between the input and that register.
// When the downstream side stalls with a result held, in_stall rises and
// the byte on the input waits; as soon as the held result is taken, a new
// byte is accepted in the same cycle.
// Reset clears the parser to sync search, empties the result register and
// selects modulo 255 sums. cfg_write_enable with cfg_write_data chooses
// modulo 256 (high) or modulo 255 (low); write it only while idle.
module radio_frame_receiver (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write_enable,
    input  wire logic       cfg_write_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            kind,
    output logic [7:0]      payload_byte,
    output logic [2:0]      status,
    output logic [7:0]      payload_count,
    output logic            last
);

    logic       mod256_reg;

    logic [8:0]  index_reg, index_next;
    logic [8:0]  end_reg, end_next;
    logic [7:0]  hi_reg, hi_next;
    logic [7:0]  lo_reg, lo_next;
    logic [15:0] hsums_reg, hsums_next;
    logic        hbad_reg, hbad_next;
    logic [15:0] sums_reg, sums_next;
    logic [7:0]  chk_reg, chk_next;

    logic        res_valid_reg, res_valid_next;
    logic        kind_reg, kind_next;
    logic [7:0]  pbyte_reg, pbyte_next;
    logic [2:0]  status_reg, status_next;
    logic [7:0]  count_reg, count_next;

    logic        accept;
    logic        fits;
    logic [9:0]  idx_p1, idx_p2;
    logic [7:0]  s1_new, s2_new;
    logic [15:0] sums_add;
    logic        pay_bad;
    logic [8:0]  plen;
    logic [2:0]  st;
    logic        at_end;

    // The input waits only while a result is held and not being taken.
    assign in_stall = res_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign out_valid     = res_valid_reg;
    assign kind          = kind_reg;
    assign payload_byte  = pbyte_reg;
    assign status        = status_reg;
    assign payload_count = count_reg;
    assign last          = kind_reg;

    always_comb
    begin
        unique case (index_reg)
            9'd0:       fits = (rx_byte == rfr_pkg::SYNC0_BYTE);
            9'd1:       fits = (rx_byte == rfr_pkg::SYNC1_BYTE);
            rfr_pkg::IDX_RESP: fits = (rx_byte == rfr_pkg::RESP_BYTE);
            rfr_pkg::IDX_CMD:  fits = (rx_byte >= rfr_pkg::CMD_MIN) &&
                                      (rx_byte <= rfr_pkg::CMD_MAX);
            rfr_pkg::IDX_LEN_HI: fits = (rx_byte == rfr_pkg::HI_NONE) ||
                                        (rx_byte == rfr_pkg::HI_ACK) ||
                                        (rx_byte == rfr_pkg::HI_NACK);
            default:    fits = 1'b1;
        endcase
    end

    assign s1_new   = rfr_pkg::mod_add(sums_reg[7:0], rx_byte, mod256_reg);
    assign s2_new   = rfr_pkg::mod_add(sums_reg[15:8], s1_new, mod256_reg);
    assign sums_add = {s2_new, s1_new};
    assign idx_p1   = {1'b0, index_reg} + 10'd1;
    assign idx_p2   = {1'b0, index_reg} + 10'd2;

    always_comb
    begin
        index_next = index_reg;
        end_next   = end_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        hsums_next = hsums_reg;
        hbad_next  = hbad_reg;
        sums_next  = sums_reg;
        chk_next   = chk_reg;
        at_end     = 1'b0;
        pay_bad    = 1'b0;
        plen       = '0;
        st         = rfr_pkg::ST_OK;

        res_valid_next = res_valid_reg && out_stall;
        kind_next      = kind_reg;
        pbyte_next     = pbyte_reg;
        status_next    = status_reg;
        count_next     = count_reg;

        if (accept)
        begin
            // The frame length is known from the high byte for ack and nack,
            // else from the low length byte.
            if (index_reg == rfr_pkg::IDX_LEN_HI &&
                (rx_byte == rfr_pkg::HI_ACK || rx_byte == rfr_pkg::HI_NACK))
                end_next = rfr_pkg::SHORT_FRAME;
            else if (index_reg == rfr_pkg::IDX_LEN_LO && end_reg == rfr_pkg::END_UNKNOWN)
                end_next = {1'b0, rx_byte} + rfr_pkg::FRAME_OVERHEAD;

            if (index_reg == rfr_pkg::IDX_LEN_HI)
                hi_next = rx_byte;
            if (index_reg == rfr_pkg::IDX_LEN_LO)
                lo_next = rx_byte;
            if (index_reg == rfr_pkg::IDX_HCHK0 && rx_byte != hsums_reg[7:0])
                hbad_next = 1'b1;
            if (index_reg == rfr_pkg::IDX_HCHK1 && rx_byte != hsums_reg[15:8])
                hbad_next = 1'b1;
            if (index_reg >= rfr_pkg::IDX_RESP && idx_p2 < {1'b0, end_next})
                sums_next = sums_add;
            if (index_reg == rfr_pkg::IDX_LEN_LO)
                hsums_next = sums_next;
            if (idx_p2 == {1'b0, end_next})
                chk_next = rx_byte;

            at_end = fits && (idx_p1 == {1'b0, end_next});

            if (at_end)
            begin
                plen = (end_next >= rfr_pkg::FRAME_OVERHEAD) ?
                       end_next - rfr_pkg::FRAME_OVERHEAD : 9'd0;
                if (hi_next == lo_next)
                begin
                    priority if (hi_next == rfr_pkg::HI_ACK)
                        st = rfr_pkg::ST_OK;
                    else if (hi_next == rfr_pkg::HI_NACK)
                        st = rfr_pkg::ST_NACK;
                    else if (hi_next == rfr_pkg::HI_NONE)
                        st = rfr_pkg::ST_EMPTY;
                    else
                        st = rfr_pkg::ST_BAD_ACK;
                end
                else
                begin
                    pay_bad = (chk_reg != sums_reg[7:0]) || (rx_byte != sums_reg[15:8]);
                    priority if (plen == 9'd0)
                        st = rfr_pkg::ST_ZERO_LEN;
                    else if (hbad_next || pay_bad)
                        st = rfr_pkg::ST_CHECK_FAIL;
                    else
                        st = rfr_pkg::ST_OK;
                end
                res_valid_next = 1'b1;
                kind_next      = 1'b1;
                pbyte_next     = '0;
                status_next    = st;
                count_next     = (st == rfr_pkg::ST_OK) ? plen[7:0] : 8'd0;
            end
            else if (fits && index_reg >= rfr_pkg::IDX_PAYLOAD &&
                     idx_p2 < {1'b0, end_next})
            begin
                res_valid_next = 1'b1;
                kind_next      = 1'b0;
                pbyte_next     = rx_byte;
                status_next    = rfr_pkg::ST_OK;
                count_next     = '0;
            end

            // A pattern break or a finished frame returns the parser to sync search.
            if (!fits || at_end)
            begin
                index_next = '0;
                end_next   = rfr_pkg::END_UNKNOWN;
                hi_next    = '0;
                lo_next    = '0;
                hsums_next = '0;
                hbad_next  = 1'b0;
                sums_next  = '0;
                chk_next   = '0;
            end
            else
                index_next = idx_p1[8:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod256_reg    <= 1'b0;
            index_reg     <= '0;
            end_reg       <= rfr_pkg::END_UNKNOWN;
            hi_reg        <= '0;
            lo_reg        <= '0;
            hsums_reg     <= '0;
            hbad_reg      <= 1'b0;
            sums_reg      <= '0;
            chk_reg       <= '0;
            res_valid_reg <= 1'b0;
            kind_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable)
                mod256_reg <= cfg_write_data;
            index_reg     <= index_next;
            end_reg       <= end_next;
            hi_reg        <= hi_next;
            lo_reg        <= lo_next;
            hsums_reg     <= hsums_next;
            hbad_reg      <= hbad_next;
            sums_reg      <= sums_next;
            chk_reg       <= chk_next;
            res_valid_reg <= res_valid_next;
            kind_reg      <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pbyte_reg  <= pbyte_next;
        status_reg <= status_next;
        count_reg  <= count_next;
    end

endmodule
`default_nettype wire
